// ===== hw/rtl/ohme_pkg.sv =====
// Shared types and constants for the ordered hash map engine.
// No dependencies.
`default_nettype none
package ohme_pkg;
  localparam int KEY_W = 32;
  localparam int HASH_W = 32;
  localparam int VAL_W = 64;
  localparam int OP_W = 2;

  localparam logic [OP_W-1:0] OP_SET = 2'd0;
  localparam logic [OP_W-1:0] OP_GET = 2'd1;
  localparam logic [OP_W-1:0] OP_DEL = 2'd2;

  localparam int IN_W = 136;
  localparam int OUT_W = 72;

  typedef struct packed {
    logic             live;
    logic [VAL_W-1:0] value;
    logic [HASH_W-1:0] hash;
    logic [KEY_W-1:0] key;
  } entry_t;
endpackage
`default_nettype wire

// ===== hw/rtl/ohme_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module ohme_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(DEPTH)-1:0] waddr,
  input  wire [WIDTH-1:0]         wdata,
  input  wire [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]        rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hw/rtl/ordered_hash_map_engine.sv =====
// Insertion-ordered hash map: one request in, one response out.
// Flow: each index probe reads the slot and then the entry it points to (a probe that ends on an
// empty slot skips the entry compare); a new key then probes for a free slot and writes the entry;
// a compaction clears the index, then copies each live entry down and probes a slot for it.
// Throughput: one item at a time; the next item is taken once the response is registered.
// Reset: control clears at once, then a clearing pass writes every slot of the index RAM
// before the first item is taken.
`default_nettype none
module ordered_hash_map_engine #(
  parameter int CAPACITY = 64,
  parameter int INDEX_SLOTS = 128
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      s_tvalid,
  output logic                     s_tready,
  // opcode, key_id, key_hash, new_value (lowest bit up)
  input  wire [ohme_pkg::IN_W-1:0] s_tdata,
  output logic                     m_tvalid,
  input  wire                      m_tready,
  // accepted, key_present, read_value (lowest bit up)
  output logic [ohme_pkg::OUT_W-1:0] m_tdata
);
  import ohme_pkg::*;

  localparam int PW = $clog2(CAPACITY);
  localparam int SW = $clog2(INDEX_SLOTS);
  localparam logic [SW:0] LAST = (SW + 1)'(INDEX_SLOTS - 1);
  localparam logic [PW:0] CAP = (PW + 1)'(CAPACITY);
  localparam logic [SW-1:0] SLOT_MAX = SW'(INDEX_SLOTS - 1);

  localparam logic [3:0] S_CLR    = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_LK_IDX = 4'd2;
  localparam logic [3:0] S_LK_ENT = 4'd3;
  localparam logic [3:0] S_LK_CMP = 4'd4;
  localparam logic [3:0] S_DEC    = 4'd5;
  localparam logic [3:0] S_CP_RD  = 4'd6;
  localparam logic [3:0] S_CP_CHK = 4'd7;
  localparam logic [3:0] S_PL_RD  = 4'd8;
  localparam logic [3:0] S_PL_CHK = 4'd9;
  localparam logic [3:0] S_INS    = 4'd10;
  localparam logic [3:0] S_FIN    = 4'd11;

  logic [3:0]        state, state_next;
  logic [SW:0]       cnt, cnt_next;
  logic [SW-1:0]     slot, slot_next;
  logic [OP_W-1:0]   op, op_next;
  logic [KEY_W-1:0]  key, key_next;
  logic [HASH_W-1:0] hash, hash_next;
  logic [VAL_W-1:0]  val, val_next;
  logic              hit, hit_next;
  logic [PW-1:0]     hit_pos, hit_pos_next;
  logic [HASH_W-1:0] hit_hash, hit_hash_next;
  logic [VAL_W-1:0]  hit_val, hit_val_next;
  logic [PW:0]       used, used_next;
  logic [PW:0]       live, live_next;
  logic [PW:0]       cp_i, cp_i_next;
  logic [PW:0]       cp_n, cp_n_next;
  logic [PW-1:0]     ppos, ppos_next;
  logic              pl_ret, pl_ret_next;
  logic              clr_ret, clr_ret_next;
  logic              res_acc, res_acc_next;
  logic              res_pres, res_pres_next;
  logic [VAL_W-1:0]  res_val, res_val_next;
  logic              out_acc;
  logic              out_pres;
  logic [VAL_W-1:0]  out_val;

  logic          idx_we;
  logic [SW-1:0] idx_waddr, idx_raddr;
  logic [PW:0]   idx_wdata, idx_rdata;
  logic          ent_we;
  logic [PW-1:0] ent_waddr, ent_raddr;
  entry_t        ent_wdata, ent_rdata;

  logic [SW-1:0] home_req, home_ent, slot_inc;

  ohme_ram #(.WIDTH(PW + 1), .DEPTH(INDEX_SLOTS)) u_index (
    .clk(clk), .we(idx_we), .waddr(idx_waddr), .wdata(idx_wdata),
    .raddr(idx_raddr), .rdata(idx_rdata)
  );

  ohme_ram #(.WIDTH($bits(entry_t)), .DEPTH(CAPACITY)) u_entry (
    .clk(clk), .we(ent_we), .waddr(ent_waddr), .wdata(ent_wdata),
    .raddr(ent_raddr), .rdata(ent_rdata)
  );

  assign home_req = SW'(hash & HASH_W'(INDEX_SLOTS - 1));
  assign home_ent = SW'(ent_rdata.hash & HASH_W'(INDEX_SLOTS - 1));
  assign slot_inc = (slot == SLOT_MAX) ? '0 : slot + 1'b1;

  assign s_tready = (state == S_IDLE);
  assign m_tdata = {6'd0, out_val, out_pres, out_acc};

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    slot_next = slot;
    op_next = op;
    key_next = key;
    hash_next = hash;
    val_next = val;
    hit_next = hit;
    hit_pos_next = hit_pos;
    hit_hash_next = hit_hash;
    hit_val_next = hit_val;
    used_next = used;
    live_next = live;
    cp_i_next = cp_i;
    cp_n_next = cp_n;
    ppos_next = ppos;
    pl_ret_next = pl_ret;
    clr_ret_next = clr_ret;
    res_acc_next = res_acc;
    res_pres_next = res_pres;
    res_val_next = res_val;
    idx_we = 1'b0;
    idx_waddr = slot;
    idx_wdata = '0;
    idx_raddr = slot;
    ent_we = 1'b0;
    ent_waddr = hit_pos;
    ent_wdata = ent_rdata;
    ent_raddr = idx_rdata[PW-1:0];

    case (state)
      S_CLR: begin
        idx_we = 1'b1;
        idx_waddr = cnt[SW-1:0];
        cnt_next = cnt + 1'b1;
        if (cnt == LAST) begin
          cnt_next = '0;
          cp_i_next = '0;
          cp_n_next = '0;
          state_next = clr_ret ? S_CP_RD : S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_tvalid) begin
          op_next = s_tdata[1:0];
          key_next = s_tdata[33:2];
          hash_next = s_tdata[65:34];
          val_next = s_tdata[129:66];
          slot_next = SW'(s_tdata[65:34] & HASH_W'(INDEX_SLOTS - 1));
          cnt_next = '0;
          hit_next = 1'b0;
          state_next = S_LK_IDX;
        end
      end
      S_LK_IDX: begin
        state_next = S_LK_ENT;
      end
      S_LK_ENT: begin
        hit_pos_next = idx_rdata[PW-1:0];
        state_next = idx_rdata[PW] ? S_LK_CMP : S_DEC;
      end
      S_LK_CMP: begin
        if (ent_rdata.live && ent_rdata.key == key) begin
          hit_next = 1'b1;
          hit_hash_next = ent_rdata.hash;
          hit_val_next = ent_rdata.value;
          state_next = S_DEC;
        end else if (cnt == LAST) begin
          state_next = S_DEC;
        end else begin
          cnt_next = cnt + 1'b1;
          slot_next = slot_inc;
          state_next = S_LK_IDX;
        end
      end
      S_DEC: begin
        res_acc_next = 1'b1;
        res_pres_next = hit;
        res_val_next = '0;
        state_next = S_FIN;
        case (op)
          OP_SET: begin
            if (hit) begin
              ent_we = 1'b1;
              ent_wdata = '{live: 1'b1, value: val, hash: hit_hash, key: key};
            end else if (live >= CAP) begin
              res_acc_next = 1'b0;
            end else if (used >= CAP) begin
              clr_ret_next = 1'b1;
              cnt_next = '0;
              state_next = S_CLR;
            end else begin
              slot_next = home_req;
              cnt_next = '0;
              ppos_next = used[PW-1:0];
              pl_ret_next = 1'b0;
              state_next = S_PL_RD;
            end
          end
          OP_GET: begin
            if (hit) begin
              res_val_next = hit_val;
            end
          end
          OP_DEL: begin
            if (hit) begin
              ent_we = 1'b1;
              ent_wdata = '{live: 1'b0, value: '0, hash: hit_hash, key: key};
              live_next = live - 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      S_CP_RD: begin
        ent_raddr = cp_i[PW-1:0];
        if (cp_i == used) begin
          used_next = cp_n;
          live_next = cp_n;
          slot_next = home_req;
          cnt_next = '0;
          ppos_next = cp_n[PW-1:0];
          pl_ret_next = 1'b0;
          state_next = S_PL_RD;
        end else begin
          state_next = S_CP_CHK;
        end
      end
      S_CP_CHK: begin
        cp_i_next = cp_i + 1'b1;
        state_next = S_CP_RD;
        if (ent_rdata.live) begin
          ent_we = 1'b1;
          ent_waddr = cp_n[PW-1:0];
          ent_wdata = ent_rdata;
          slot_next = home_ent;
          cnt_next = '0;
          ppos_next = cp_n[PW-1:0];
          cp_n_next = cp_n + 1'b1;
          pl_ret_next = 1'b1;
          state_next = S_PL_RD;
        end
      end
      S_PL_RD: begin
        state_next = S_PL_CHK;
      end
      S_PL_CHK: begin
        if (!idx_rdata[PW]) begin
          idx_we = 1'b1;
          idx_wdata = {1'b1, ppos};
          state_next = pl_ret ? S_CP_RD : S_INS;
        end else if (cnt == LAST) begin
          res_acc_next = 1'b0;
          res_pres_next = 1'b0;
          res_val_next = '0;
          state_next = pl_ret ? S_CP_RD : S_FIN;
        end else begin
          cnt_next = cnt + 1'b1;
          slot_next = slot_inc;
          state_next = S_PL_RD;
        end
      end
      S_INS: begin
        ent_we = 1'b1;
        ent_waddr = used[PW-1:0];
        ent_wdata = '{live: 1'b1, value: val, hash: hash, key: key};
        used_next = used + 1'b1;
        live_next = live + 1'b1;
        res_acc_next = 1'b1;
        res_pres_next = 1'b0;
        res_val_next = '0;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (!m_tvalid || m_tready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      cnt <= '0;
      clr_ret <= 1'b0;
      used <= '0;
      live <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      clr_ret <= (state == S_CP_RD) ? 1'b0 : clr_ret_next;
      used <= used_next;
      live <= live_next;
      if (state == S_FIN && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    slot <= slot_next;
    op <= op_next;
    key <= key_next;
    hash <= hash_next;
    val <= val_next;
    hit <= hit_next;
    hit_pos <= hit_pos_next;
    hit_hash <= hit_hash_next;
    hit_val <= hit_val_next;
    cp_i <= cp_i_next;
    cp_n <= cp_n_next;
    ppos <= ppos_next;
    pl_ret <= pl_ret_next;
    res_acc <= res_acc_next;
    res_pres <= res_pres_next;
    res_val <= res_val_next;
    if (state == S_FIN && (!m_tvalid || m_tready)) begin
      out_acc <= res_acc;
      out_pres <= res_pres;
      out_val <= res_val;
    end
  end

  a_live_le_used: assert property (@(posedge clk) disable iff (rst) live <= used)
    else $error("live count exceeds used positions");
  a_used_le_cap: assert property (@(posedge clk) disable iff (rst) used <= CAP)
    else $error("used positions exceed capacity");
  a_refuse_clean: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[0]) |-> (!m_tdata[1] && m_tdata[65:2] == '0))
    else $error("refused item carries data");
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == S_LK_IDX))
    else $error("accepted item did not start a lookup");
endmodule
`default_nettype wire
